// ===== rtl/pfpc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfpc_pkg: shared definitions of the pose-follow controller
// Field widths, fixed-point constants, register indexes and the arctangent
// table of the vectoring unit.
// ----------------------------------------------------------------------------
package pfpc_pkg;

  // Field widths
  localparam int POS_W     = 16;   // Q5.10 position
  localparam int HDG_W     = 15;   // Q2.12 heading
  localparam int SPEED_W   = 16;   // output speeds
  localparam int GAIN_W    = 16;   // Q8.8 gains
  localparam int LIMIT_W   = 15;   // speed limits and distance tolerance
  localparam int HTOL_W    = 14;   // heading tolerance

  // Internal widths
  localparam int DIFF_W    = POS_W + 1;   // pose difference
  localparam int ABS_W     = POS_W;       // magnitude of a difference
  localparam int SUMSQ_W   = 33;          // dx^2 + dy^2
  localparam int ROOT_W    = 17;          // floor square root
  localparam int MAG_W     = 17;          // multiplier operand A
  localparam int PROD_W    = MAG_W + GAIN_W;
  localparam int CX_W      = 28;          // vectoring x and y
  localparam int CZ_W      = 20;          // vectoring angle, Q.16
  localparam int BEAR_W    = 16;          // bearing, Q3.12
  localparam int ANG_W     = 18;          // angles mapped to 0..2pi
  localparam int ERR_W     = 17;          // heading error magnitude
  localparam int STEP_W    = 5;           // vectoring step index

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_LINEAR_GAIN   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGULAR_GAIN  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_LINEAR_MAX    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ANGULAR_MAX   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DIST_TOL      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_HEADING_TOL   = 3'd5;

  // Fixed-point constants
  localparam logic signed [BEAR_W-1:0] PI_Q12      = 16'sd12868;
  localparam logic signed [ANG_W-1:0]  TWO_PI_Q12  = 18'sd25736;
  localparam logic        [ERR_W-1:0]  PI_MAG_Q12  = 17'd12868;
  localparam logic signed [CZ_W-1:0]   HALF_PI_Q16 = 20'sd102944;

  // Default configuration
  localparam logic [GAIN_W-1:0]  LINEAR_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]  ANGULAR_GAIN_RST = 16'd256;
  localparam logic [LIMIT_W-1:0] LINEAR_MAX_RST   = 15'd2048;
  localparam logic [LIMIT_W-1:0] ANGULAR_MAX_RST  = 15'd8192;
  localparam logic [LIMIT_W-1:0] DIST_TOL_RST     = 15'd102;
  localparam logic [HTOL_W-1:0]  HEADING_TOL_RST  = 14'd41;

  localparam int CORDIC_ITERATIONS_DEF = 16;

  // round(atan(2^-i) * 2^16); zero beyond the last useful step
  function automatic logic signed [CZ_W-1:0] atan_q16(input logic [STEP_W-1:0] idx);
    logic signed [CZ_W-1:0] v;
    begin
      case (idx)
        5'd0:    v = 20'sd51472;
        5'd1:    v = 20'sd30386;
        5'd2:    v = 20'sd16055;
        5'd3:    v = 20'sd8150;
        5'd4:    v = 20'sd4091;
        5'd5:    v = 20'sd2047;
        5'd6:    v = 20'sd1024;
        5'd7:    v = 20'sd512;
        5'd8:    v = 20'sd256;
        5'd9:    v = 20'sd128;
        5'd10:   v = 20'sd64;
        5'd11:   v = 20'sd32;
        5'd12:   v = 20'sd16;
        5'd13:   v = 20'sd8;
        5'd14:   v = 20'sd4;
        5'd15:   v = 20'sd2;
        5'd16:   v = 20'sd1;
        default: v = 20'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== rtl/pfpc_pose_if.sv =====
// ----------------------------------------------------------------------------
// pfpc_pose_if: pose update channel
// Valid/ready channel that carries one pose from the leader or the follower.
// ----------------------------------------------------------------------------
interface pfpc_pose_if import pfpc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic signed [HDG_W-1:0]  heading;

  modport source (output valid, mode, pos_x, pos_y, heading, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, heading, output ready);
endinterface

// ===== rtl/pfpc_cmd_if.sv =====
// ----------------------------------------------------------------------------
// pfpc_cmd_if: drive command channel
// Valid/ready channel that carries one linear and angular speed command.
// ----------------------------------------------------------------------------
interface pfpc_cmd_if import pfpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [SPEED_W-1:0] fwd_rate;
  logic signed [SPEED_W-1:0] turn_rate;

  modport source (output valid, fwd_rate, turn_rate, input ready);
  modport sink   (input valid, fwd_rate, turn_rate, output ready);
endinterface

// ===== rtl/pfpc_sqrt.sv =====
// ----------------------------------------------------------------------------
// pfpc_sqrt: iterative integer square root
// Restoring digit-by-digit root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pfpc_sqrt import pfpc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUMSQ_W-1:0]  radicand,
  output logic                busy,
  output logic [ROOT_W-1:0]   root
);

  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 4;

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == STEP_W'(ROOT_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= RAD_W'(radicand);
      rem  <= '0;
      root <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], take};
      cnt  <= cnt + STEP_W'(1);
    end
  end

endmodule

// ===== rtl/pfpc_cordic.sv =====
// ----------------------------------------------------------------------------
// pfpc_cordic: iterative vectoring arctangent
// One shift-add micro-rotation per cycle over a shared adder set.
// ----------------------------------------------------------------------------
module pfpc_cordic import pfpc_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [DIFF_W-1:0]  dx,
  input  logic signed [DIFF_W-1:0]  dy,
  output logic                      busy,
  output logic signed [BEAR_W-1:0]  bearing
);

  logic signed [CX_W-1:0]  x;
  logic signed [CX_W-1:0]  y;
  logic signed [CZ_W-1:0]  z;
  logic [STEP_W-1:0]       cnt;
  logic                    flat;
  logic signed [BEAR_W-1:0] flat_bearing;

  logic signed [CX_W-1:0]  xi;
  logic signed [CX_W-1:0]  yi;
  logic signed [CX_W-1:0]  xs;
  logic signed [CX_W-1:0]  ys;
  logic signed [CZ_W-1:0]  z_rnd;

  always_comb begin
    xi    = {{(CX_W-DIFF_W-8){dx[DIFF_W-1]}}, dx, 8'h00};
    yi    = {{(CX_W-DIFF_W-8){dy[DIFF_W-1]}}, dy, 8'h00};
    xs    = x >>> cnt;
    ys    = y >>> cnt;
    z_rnd = (z + CZ_W'(8)) >>> 4;
    bearing = flat ? flat_bearing : BEAR_W'(z_rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= (dy != '0);
    end else if (busy && cnt == STEP_W'(CORDIC_ITERATIONS - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt          <= '0;
      flat         <= (dy == '0);
      flat_bearing <= dx[DIFF_W-1] ? PI_Q12 : '0;
      // Quarter-turn pre-rotation brings the vector into the right half-plane.
      if (dx[DIFF_W-1]) begin
        if (!dy[DIFF_W-1]) begin
          x <= yi;
          y <= -xi;
          z <= HALF_PI_Q16;
        end else begin
          x <= -yi;
          y <= xi;
          z <= -HALF_PI_Q16;
        end
      end else begin
        x <= xi;
        y <= yi;
        z <= '0;
      end
    end else if (busy) begin
      cnt <= cnt + STEP_W'(1);
      if (y > 0) begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_q16(cnt);
      end else begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_q16(cnt);
      end
    end
  end

endmodule

// ===== rtl/pose_follow_p_controller.sv =====
// ----------------------------------------------------------------------------
// pose_follow_p_controller: go-to-goal proportional controller
// Keeps the latest leader and follower poses and issues one drive command
// each time both have been refreshed.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake         payload
//   -------  ---  ----------------  -----------------------------------------
//   pose     in   valid / ready     mode, pos_x, pos_y, heading
//   cmd      out  valid / ready     fwd_rate, turn_rate
//   cfg      in   cfg_we only       cfg_addr, cfg_data
//
// A transfer that leaves both sources fresh starts a command that runs through
// the setup states S_DIFF, S_SQX, S_SQY and S_SUM, waits in S_WAIT on the
// 17-step square root, then takes S_ERR for the error, S_MULL and S_MULA for
// the two gain products, S_SAT for saturation and S_OUT, which loads the
// result into the output register. The vectoring unit starts in S_SQX and runs
// alongside the square root; S_WAIT holds until both have finished. The pose
// channel is not ready while a command is being worked out. A finished command
// waits in the output register while new poses are still accepted; only a
// second command waits for the first to leave. Reset is synchronous and
// restores the default configuration and clears both fresh flags.
//
module pose_follow_p_controller import pfpc_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERATIONS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pfpc_pose_if.sink              pose,
  pfpc_cmd_if.source             cmd
);

  // Sequencer states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIFF = 11'b00000000010,
    S_SQX  = 11'b00000000100,
    S_SQY  = 11'b00000001000,
    S_SUM  = 11'b00000010000,
    S_WAIT = 11'b00000100000,
    S_ERR  = 11'b00001000000,
    S_MULL = 11'b00010000000,
    S_MULA = 11'b00100000000,
    S_SAT  = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  typedef struct packed {
    logic             neg;
    logic [ERR_W-1:0] mag;
  } turn_t;

  state_t state;
  state_t state_next;

  // Configuration registers
  logic [GAIN_W-1:0]  linear_gain;
  logic [GAIN_W-1:0]  angular_gain;
  logic [LIMIT_W-1:0] fwd_limit;
  logic [LIMIT_W-1:0] turn_limit;
  logic [LIMIT_W-1:0] distance_tolerance;
  logic [HTOL_W-1:0]  heading_tolerance;

  // Stored poses; they are always written before a command reads them.
  logic signed [POS_W-1:0] leader_x;
  logic signed [POS_W-1:0] leader_y;
  logic signed [HDG_W-1:0] leader_heading;
  logic signed [POS_W-1:0] follower_x;
  logic signed [POS_W-1:0] follower_y;
  logic signed [HDG_W-1:0] follower_heading;
  logic                    leader_fresh;
  logic                    follower_fresh;

  // Datapath registers
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic [PROD_W-1:0]         prod;
  logic [SUMSQ_W-1:0]        sumsq;
  logic                      near;
  logic                      err_neg;
  logic [ERR_W-1:0]          err_mag;
  logic                      ang_zero;
  logic signed [SPEED_W-1:0] lin_q;
  logic signed [SPEED_W-1:0] ang_q;
  logic                      out_valid;
  logic signed [SPEED_W-1:0] out_lin;
  logic signed [SPEED_W-1:0] out_ang;

  // Shared multiplier operands
  logic [MAG_W-1:0]  mul_a;
  logic [GAIN_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  logic [ABS_W-1:0]          adx;
  logic [ABS_W-1:0]          ady;
  logic                      pose_acc;
  logic                      completes;
  logic                      out_free;

  // Iterative units
  logic                      sqrt_start;
  logic                      sqrt_busy;
  logic [ROOT_W-1:0]         gap;
  logic                      cordic_start;
  logic                      cordic_busy;
  logic signed [BEAR_W-1:0]  bearing;

  turn_t                     turn_far;
  turn_t                     turn_near;
  turn_t                     turn_sel;
  logic                      near_now;

  // Map an angle to 0..2pi.
  function automatic logic signed [ANG_W-1:0] wrap_pos(input logic signed [ANG_W-1:0] a);
    begin
      return (a < 0) ? a + TWO_PI_Q12 : a;
    end
  endfunction

  // Shortest-turn sign rule on target b and own angle t; errors beyond pi
  // are not wrapped.
  function automatic turn_t turn_error(input logic signed [ANG_W-1:0] b,
                                       input logic signed [ANG_W-1:0] t);
    turn_t r;
    logic signed [ANG_W-1:0] d;
    begin
      d     = (b > t) ? b - t : t - b;
      r.mag = ERR_W'(d);
      r.neg = ((b > t) && (r.mag > PI_MAG_Q12)) || ((b < t) && (r.mag < PI_MAG_Q12));
      return r;
    end
  endfunction

  // Round the Q8.8 product half up, clamp the magnitude and restore the sign.
  function automatic logic signed [SPEED_W-1:0] scale_sat(input logic [PROD_W-1:0] p,
                                                         input logic [LIMIT_W-1:0] lim,
                                                         input logic neg);
    logic [PROD_W:0]       rnd;
    logic [LIMIT_W-1:0]    m;
    logic [SPEED_W-1:0]    u;
    begin
      rnd = (PROD_W+1)'(p) + (PROD_W+1)'(128);
      m   = (rnd[PROD_W:8] > (PROD_W-7)'(lim)) ? lim : rnd[LIMIT_W+7:8];
      u   = SPEED_W'(m);
      return neg ? -$signed(u) : $signed(u);
    end
  endfunction

  // Handshakes
  assign pose.ready    = (state == S_IDLE);
  assign pose_acc      = pose.valid && pose.ready;
  assign completes     = pose_acc && (pose.mode ? leader_fresh : follower_fresh);
  assign out_free      = !out_valid || cmd.ready;
  assign cmd.valid     = out_valid;
  assign cmd.fwd_rate  = out_lin;
  assign cmd.turn_rate = out_ang;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain        <= LINEAR_GAIN_RST;
      angular_gain       <= ANGULAR_GAIN_RST;
      fwd_limit          <= LINEAR_MAX_RST;
      turn_limit         <= ANGULAR_MAX_RST;
      distance_tolerance <= DIST_TOL_RST;
      heading_tolerance  <= HEADING_TOL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LINEAR_GAIN:  linear_gain        <= cfg_data[GAIN_W-1:0];
        REG_ANGULAR_GAIN: angular_gain       <= cfg_data[GAIN_W-1:0];
        REG_LINEAR_MAX:   fwd_limit          <= cfg_data[LIMIT_W-1:0];
        REG_ANGULAR_MAX:  turn_limit         <= cfg_data[LIMIT_W-1:0];
        REG_DIST_TOL:     distance_tolerance <= cfg_data[LIMIT_W-1:0];
        REG_HEADING_TOL:  heading_tolerance  <= cfg_data[HTOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pose storage. The fresh flag of the source that completes a pair is never
  // set; both flags drop as the command starts.
  always_ff @(posedge clk) begin
    if (rst) begin
      leader_fresh   <= 1'b0;
      follower_fresh <= 1'b0;
    end else if (pose_acc) begin
      if (completes) begin
        leader_fresh   <= 1'b0;
        follower_fresh <= 1'b0;
      end else if (pose.mode) begin
        follower_fresh <= 1'b1;
      end else begin
        leader_fresh   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pose_acc) begin
      if (pose.mode) begin
        follower_x       <= pose.pos_x;
        follower_y       <= pose.pos_y;
        follower_heading <= pose.heading;
      end else begin
        leader_x         <= pose.pos_x;
        leader_y         <= pose.pos_y;
        leader_heading   <= pose.heading;
      end
    end
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (completes) state_next = S_DIFF;
      S_DIFF: state_next = S_SQX;
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_SUM;
      S_SUM:  state_next = S_WAIT;
      S_WAIT: if (!sqrt_busy && !cordic_busy) state_next = S_ERR;
      S_ERR:  state_next = S_MULL;
      S_MULL: state_next = S_MULA;
      S_MULA: state_next = S_SAT;
      S_SAT:  state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // The single multiplier serves both squares and both gain products.
  always_comb begin
    adx = dx[DIFF_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ady = dy[DIFF_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    case (state)
      S_SQX: begin
        mul_a = MAG_W'(adx);
        mul_b = adx;
      end
      S_SQY: begin
        mul_a = MAG_W'(ady);
        mul_b = ady;
      end
      S_MULL: begin
        mul_a = MAG_W'(gap);
        mul_b = linear_gain;
      end
      default: begin
        mul_a = err_mag;
        mul_b = angular_gain;
      end
    endcase
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Heading error for both cases, selected by the distance test.
  always_comb begin
    near_now  = (gap <= ROOT_W'(distance_tolerance));
    turn_far  = turn_error(wrap_pos(ANG_W'(bearing)), wrap_pos(ANG_W'(follower_heading)));
    turn_near = turn_error(wrap_pos(ANG_W'(leader_heading)),
                           wrap_pos(ANG_W'(follower_heading)));
    turn_sel  = near_now ? turn_near : turn_far;
  end

  assign cordic_start = (state == S_SQX);
  assign sqrt_start   = (state == S_SUM);

  always_ff @(posedge clk) begin
    case (state)
      S_DIFF: begin
        dx <= DIFF_W'(leader_x) - DIFF_W'(follower_x);
        dy <= DIFF_W'(leader_y) - DIFF_W'(follower_y);
      end
      S_SQX: prod <= mul_p;
      S_SQY: begin
        sumsq <= SUMSQ_W'(prod);
        prod  <= mul_p;
      end
      S_ERR: begin
        near     <= near_now;
        err_neg  <= turn_sel.neg;
        err_mag  <= turn_sel.mag;
        // Inside the distance tolerance a small heading error commands no turn.
        ang_zero <= near_now && (turn_sel.mag <= ERR_W'(heading_tolerance));
      end
      S_MULL: prod <= mul_p;
      S_MULA: begin
        lin_q <= near ? '0 : scale_sat(prod, fwd_limit, 1'b0);
        prod  <= mul_p;
      end
      S_SAT: ang_q <= ang_zero ? '0 : scale_sat(prod, turn_limit, err_neg);
      default: ;
    endcase
  end

  // Output register; it is loaded only when empty or being emptied.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (cmd.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_lin <= lin_q;
      out_ang <= ang_q;
    end
  end

  pfpc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (sumsq + SUMSQ_W'(prod)),
    .busy     (sqrt_busy),
    .root     (gap)
  );

  pfpc_cordic #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cordic_start),
    .dx      (dx),
    .dy      (dy),
    .busy    (cordic_busy),
    .bearing (bearing)
  );

endmodule
